/* src/stk_pkg.sv */
// Shared types and constants for the word stack with insert and remove at depth.
package stk_pkg;

  // Default sizes
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_WORD_WIDTH  = 32;

  localparam int CMD_W = 3;
  localparam int ST_W  = 2;

  // Command codes carried on in_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  // Result status carried on out_tuser
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Move applied to the whole cell row at once
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_DOWN = 2'd1,  // open a slot at the selected depth, deeper entries move away from top
    OP_UP   = 2'd2   // close the slot at the selected depth, deeper entries move toward top
  } op_t;

endpackage

/* src/stk_cell.sv */
// One stack slot: holds a word and moves it to or from its neighbors.
module stk_cell
  import stk_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int CNT_W      = 7,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  op_t                   op,
  input  logic [CNT_W-1:0]      depth,
  input  logic [WORD_WIDTH-1:0] value,
  input  logic [WORD_WIDTH-1:0] above,   // word of the slot nearer the top
  input  logic [WORD_WIDTH-1:0] below,   // word of the slot farther from the top
  output logic [WORD_WIDTH-1:0] word_o,
  output logic [WORD_WIDTH-1:0] sel_o    // own word when selected, else zero
);

  logic [WORD_WIDTH-1:0] data_r;
  logic [WORD_WIDTH-1:0] data_nxt;
  logic                  is_sel;
  logic                  is_shallow;

  assign is_sel     = (depth == CNT_W'(IDX));
  assign is_shallow = (CNT_W'(IDX) < depth);

  // Next word for this slot
  always_comb begin
    data_nxt = data_r;
    unique case (op)
      OP_HOLD: data_nxt = data_r;
      OP_DOWN: begin
        if (is_sel) data_nxt = value;
        else if (!is_shallow) data_nxt = above;
      end
      OP_UP: begin
        if (!is_shallow) data_nxt = below;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word_o = data_r;
  assign sel_o  = is_sel ? data_r : '0;

endmodule

/* src/stk_ctrl.sv */
// Command decode, range and fill checks, and the entry count.
module stk_ctrl
  import stk_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int CNT_W       = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [CMD_W-1:0] cmd,
  input  logic [CNT_W-1:0] depth_index,
  output op_t              op,
  output logic [CNT_W-1:0] cell_depth,
  output status_t          status,
  output logic             rd_en,
  output logic [CNT_W-1:0] count_nxt
);

  logic [CNT_W-1:0] count_r;
  logic             full;
  logic             empty;
  op_t              op_raw;

  assign full  = (count_r == CNT_W'(STACK_DEPTH));
  assign empty = (count_r == '0);

  // Decode and check
  always_comb begin
    op_raw     = OP_HOLD;
    cell_depth = '0;
    status     = ST_OK;
    rd_en      = 1'b0;
    count_nxt  = count_r;
    unique case (cmd_t'(cmd))
      CMD_PUSH: begin
        if (full) status = ST_FULL;
        else begin
          op_raw    = OP_DOWN;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP: begin
        if (empty) status = ST_EMPTY;
        else begin
          op_raw    = OP_UP;
          rd_en     = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_PEEK: begin
        if (empty) status = ST_EMPTY;
        else rd_en = 1'b1;
      end
      CMD_INSERT: begin
        cell_depth = depth_index;
        if (depth_index > count_r) status = ST_RANGE;
        else if (full) status = ST_FULL;
        else begin
          op_raw    = OP_DOWN;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        cell_depth = depth_index;
        if (depth_index >= count_r) status = ST_RANGE;
        else begin
          op_raw    = OP_UP;
          rd_en     = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

  // Cells move only on an accepted item
  assign op = accept ? op_raw : OP_HOLD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

/* src/stack_with_depth_insert_remove.sv */
// Top level: word stack built as a row of cells, with insert and remove at depth.
//
//  channel | dir | tdata (low bit up)            | tuser      | accepted when
//  in_     | in  | depth_index, value            | cmd        | in_tvalid & in_tready
//  out_    | out | read_value, count             | status     | out_tvalid & out_tready
//
// All cells shift in parallel at the accepting edge, and the result is loaded
// into the output register at that same edge.
// A new item is taken every cycle unless the output register holds an untaken result.
// Reset (rst_n low, synchronous) clears the count and the output valid only;
// cell contents stay as they are and are read only after being written.
module stack_with_depth_insert_remove
  import stk_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH,
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1),
  localparam int IN_W       = ((CNT_W + WORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((WORD_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // depth_index, value, zero fill
  input  logic [CMD_W-1:0] in_tuser,   // cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // read_value, count, zero fill
  output logic [ST_W-1:0]  out_tuser   // status
);

  logic                  accept;
  logic [CNT_W-1:0]      depth_index;
  logic [WORD_WIDTH-1:0] value;
  op_t                   op;
  logic [CNT_W-1:0]      cell_depth;
  status_t               status;
  logic                  rd_en;
  logic [CNT_W-1:0]      count_nxt;
  logic [WORD_WIDTH-1:0] words [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] sels  [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] rd_word;

  logic                  out_valid_r;
  logic [WORD_WIDTH-1:0] rd_value_r;
  logic [CNT_W-1:0]      count_out_r;
  logic [ST_W-1:0]       status_r;

  assign depth_index = in_tdata[CNT_W-1:0];
  assign value       = in_tdata[CNT_W+WORD_WIDTH-1:CNT_W];
  assign in_tready   = !out_valid_r || out_tready;
  assign accept      = in_tvalid && in_tready;

  stk_ctrl #(
    .STACK_DEPTH(STACK_DEPTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (in_tuser),
    .depth_index(depth_index),
    .op         (op),
    .cell_depth (cell_depth),
    .status     (status),
    .rd_en      (rd_en),
    .count_nxt  (count_nxt)
  );

  // Cell row, index 0 is the top of the stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] above;
    logic [WORD_WIDTH-1:0] below;
    if (i == 0) begin : g_top
      assign above = value;
    end else begin : g_mid_a
      assign above = words[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_mid_b
      assign below = words[i+1];
    end
    stk_cell #(
      .WORD_WIDTH(WORD_WIDTH),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk   (clk),
      .op    (op),
      .depth (cell_depth),
      .value (value),
      .above (above),
      .below (below),
      .word_o(words[i]),
      .sel_o (sels[i])
    );
  end

  // Word at the selected depth; at most one cell, the selected one, drives nonzero
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      rd_word = rd_word | sels[i];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_value_r  <= rd_en ? rd_word : '0;
      count_out_r <= count_nxt;
      status_r    <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({count_out_r, rd_value_r});
  assign out_tuser  = status_r;

endmodule
